/* rtl/second_order_recurrence_term_mod_macros.svh */
// Assertion macros shared by the recurrence term block
`ifndef SECOND_ORDER_RECURRENCE_TERM_MOD_MACROS_SVH
`define SECOND_ORDER_RECURRENCE_TERM_MOD_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SOREC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SOREC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sorec_pkg.sv */
// Shared types and constants for the recurrence term block
package sorec_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int CFG_INDEX_W   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_A      = 3'd0,
    REG_COEF_B      = 3'd1,
    REG_FIRST_TERM  = 3'd2,
    REG_SECOND_TERM = 3'd3,
    REG_MODULUS     = 3'd4
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_F,
    ST_RED_S,
    ST_RED_A,
    ST_RED_B,
    ST_STEP,
    ST_MAT,
    ST_FIN0,
    ST_FIN1,
    ST_DONE
  } seq_state_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic ready;
    logic res_valid;
  } seq_stat_t;

endpackage

/* rtl/sorec_mulmod.sv */
// Shift-and-add modular multiplier: result = (init + x * y) mod modulus
`include "second_order_recurrence_term_mod_macros.svh"

module sorec_mulmod import sorec_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x_in,
  input  logic [WIDTH-1:0] y_in,
  input  logic [WIDTH-1:0] init,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  logic             busy;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] r;

  // (a + b) mod m for a and b already below m, no carry out needed
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  assign done   = busy && (y == '0);
  assign result = r;

  // Track an operation in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Load operands, then consume one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      y <= y_in;
      r <= init;
    end else if (busy && (y != '0)) begin
      if (y[0]) begin
        r <= add_mod(r, x, modulus);
      end
      x <= add_mod(x, x, modulus);
      y <= y >> 1;
    end
  end

  `SOREC_ASSERT_IMPL(a_start_when_idle, clk, rst, start, !busy, "mulmod started while busy")
  `SOREC_ASSERT_NEXT(a_busy_holds, clk, rst, busy && (y != '0), busy, "mulmod dropped busy early")
  `SOREC_ASSERT_NEXT(a_done_ends, clk, rst, done, !busy, "mulmod still busy after done")

endmodule

/* rtl/sorec_seq.sv */
// Sequencer: reductions, square-and-multiply matrix power and final combine
module sorec_seq import sorec_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] term_index,
  input  logic [WIDTH-1:0] coef_a,
  input  logic [WIDTH-1:0] coef_b,
  input  logic [WIDTH-1:0] first_term,
  input  logic [WIDTH-1:0] second_term,
  input  logic [WIDTH-1:0] modulus,
  input  logic             take,
  output seq_stat_t        stat,
  output logic [WIDTH-1:0] res
);

  localparam logic [WIDTH-1:0] ONE_W   = WIDTH'(1);
  localparam logic [WIDTH-1:0] TWO_W   = WIDTH'(2);
  localparam logic [WIDTH-1:0] THREE_W = WIDTH'(3);
  localparam logic [2:0]       LAST_PROD = 3'd7;

  seq_state_t       state, state_next;
  logic             issued, issued_next;
  logic             sq;
  logic [2:0]       prod;
  logic [WIDTH-1:0] k;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] ft_r, st_r;
  logic [WIDTH-1:0] acc00, acc01, acc10, acc11;
  logic [WIDTH-1:0] base00, base01, base10, base11;
  logic [WIDTH-1:0] part, n00, n01, n10;

  logic             mm_start;
  logic [WIDTH-1:0] mm_x, mm_y, mm_init;
  logic             mm_done;
  logic [WIDTH-1:0] mm_r;
  logic [WIDTH-1:0] one;
  logic [WIDTH-1:0] p00, p01, p10, p11;

  sorec_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .x_in    (mm_x),
    .y_in    (mm_y),
    .init    (mm_init),
    .modulus (modulus),
    .done    (mm_done),
    .result  (mm_r)
  );

  // 1 mod m, zero when the modulus is one
  assign one = {{(WIDTH-1){1'b0}}, (modulus[WIDTH-1:1] != '0)};

  // Left operand of a matrix product: base when squaring, else accumulator
  assign p00 = sq ? base00 : acc00;
  assign p01 = sq ? base01 : acc01;
  assign p10 = sq ? base10 : acc10;
  assign p11 = sq ? base11 : acc11;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Next state, multiplier operands and status
  always_comb begin
    state_next     = state;
    issued_next    = issued;
    mm_start       = 1'b0;
    mm_x           = one;
    mm_y           = '0;
    mm_init        = '0;
    stat.ready     = 1'b0;
    stat.res_valid = 1'b0;

    // Every product state issues each product once, then waits for the unit
    if ((state != ST_IDLE) && (state != ST_STEP) && (state != ST_DONE)) begin
      mm_start    = !issued;
      issued_next = issued ? !mm_done : 1'b1;
    end

    unique case (state)
      ST_IDLE: begin
        stat.ready = 1'b1;
        if (start) begin
          state_next = (modulus == '0) ? ST_DONE : ST_RED_F;
        end
      end
      ST_RED_F: begin
        mm_y = first_term;
        if (mm_done) begin
          state_next = ST_RED_S;
        end
      end
      ST_RED_S: begin
        mm_y = second_term;
        if (mm_done) begin
          state_next = (k < THREE_W) ? ST_DONE : ST_RED_A;
        end
      end
      ST_RED_A: begin
        mm_y = coef_a;
        if (mm_done) begin
          state_next = ST_RED_B;
        end
      end
      ST_RED_B: begin
        mm_y = coef_b;
        if (mm_done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = (e == '0) ? ST_FIN0 : ST_MAT;
      end
      ST_MAT: begin
        unique case (prod)
          3'd0: begin mm_x = p00; mm_y = base00; end
          3'd1: begin mm_x = p01; mm_y = base10; mm_init = part; end
          3'd2: begin mm_x = p00; mm_y = base01; end
          3'd3: begin mm_x = p01; mm_y = base11; mm_init = part; end
          3'd4: begin mm_x = p10; mm_y = base00; end
          3'd5: begin mm_x = p11; mm_y = base10; mm_init = part; end
          3'd6: begin mm_x = p10; mm_y = base01; end
          3'd7: begin mm_x = p11; mm_y = base11; mm_init = part; end
          default: ;
        endcase
        if (mm_done && (prod == LAST_PROD)) begin
          if (sq) begin
            state_next = ST_STEP;
          end else if (e[WIDTH-1:1] == '0) begin
            state_next = ST_FIN0;
          end
        end
      end
      ST_FIN0: begin
        mm_x = ft_r;
        mm_y = acc01;
        if (mm_done) begin
          state_next = ST_FIN1;
        end
      end
      ST_FIN1: begin
        mm_x    = st_r;
        mm_y    = acc11;
        mm_init = res;
        if (mm_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        stat.res_valid = 1'b1;
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          k      <= term_index;
          e      <= term_index - TWO_W;
          res    <= '0;
          acc00  <= one;
          acc01  <= '0;
          acc10  <= '0;
          acc11  <= one;
          base00 <= '0;
          base10 <= one;
        end
      end
      ST_RED_F: begin
        if (mm_done) begin
          ft_r <= mm_r;
          res  <= mm_r;
        end
      end
      ST_RED_S: begin
        if (mm_done) begin
          st_r <= mm_r;
          if (k != ONE_W) begin
            res <= mm_r;
          end
        end
      end
      ST_RED_A: begin
        if (mm_done) begin
          base11 <= mm_r;
        end
      end
      ST_RED_B: begin
        if (mm_done) begin
          base01 <= mm_r;
        end
      end
      ST_STEP: begin
        // Multiply in the low exponent bit first, else go straight to squaring
        sq   <= !e[0];
        prod <= '0;
      end
      ST_MAT: begin
        if (mm_done) begin
          prod <= prod + 3'd1;
          unique case (prod)
            3'd1: n00 <= mm_r;
            3'd3: n01 <= mm_r;
            3'd5: n10 <= mm_r;
            3'd7: begin
              // Commit the whole product at once
              if (sq) begin
                base00 <= n00;
                base01 <= n01;
                base10 <= n10;
                base11 <= mm_r;
                e      <= e >> 1;
              end else begin
                acc00 <= n00;
                acc01 <= n01;
                acc10 <= n10;
                acc11 <= mm_r;
                sq    <= 1'b1;
              end
            end
            default: part <= mm_r;
          endcase
        end
      end
      ST_FIN0, ST_FIN1: begin
        if (mm_done) begin
          res <= mm_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/second_order_recurrence_term_mod.sv */
// Top level: configuration registers, sequencer and result output register
//
// Returns X(k) mod p for X(n+1) = a*X(n) + b*X(n-1), X(1) = first_term,
// X(2) = second_term, by raising the companion matrix [[0,b],[1,a]] to the
// power k-2 with square-and-multiply. One item is in work at a time and
// in_stall is high until its result is in the output register. All
// products run on one shared shift-and-add modular multiplier.
// An item first spends two products reducing the terms; indices 1 and 2
// (and 0) stop there. Otherwise two more reduce the coefficients, then each
// bit of k-2 costs one matrix squaring (eight products, none for the top bit)
// plus one more matrix product when the bit is set, and two products combine
// the result. A zero modulus sends the item straight to the done state with
// a result of 0. Configuration writes are always taken and must only happen
// while no item is in work.
module second_order_recurrence_term_mod import sorec_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // item input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WIDTH-1:0]       term_index,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WIDTH-1:0]       term_value,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]       cfg_data
);

  localparam logic [WIDTH-1:0] ONE_W_INIT = WIDTH'(1);

  logic [WIDTH-1:0] coef_a;
  logic [WIDTH-1:0] coef_b;
  logic [WIDTH-1:0] first_term;
  logic [WIDTH-1:0] second_term;
  logic [WIDTH-1:0] modulus;

  seq_stat_t        stat;
  logic [WIDTH-1:0] res;
  logic             accept;
  logic             take;

  assign cfg_ready = 1'b1;
  assign in_stall  = !stat.ready;
  assign accept    = in_valid && stat.ready;
  // Move the result across when the output register is empty or draining
  assign take      = stat.res_valid && (!out_valid || !out_stall);

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a      <= ONE_W_INIT;
      coef_b      <= ONE_W_INIT;
      first_term  <= ONE_W_INIT;
      second_term <= ONE_W_INIT;
      modulus     <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_A:      coef_a      <= cfg_data;
        REG_COEF_B:      coef_b      <= cfg_data;
        REG_FIRST_TERM:  first_term  <= cfg_data;
        REG_SECOND_TERM: second_term <= cfg_data;
        REG_MODULUS:     modulus     <= cfg_data;
        default: ;
      endcase
    end
  end

  sorec_seq #(.WIDTH(WIDTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .term_index  (term_index),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .first_term  (first_term),
    .second_term (second_term),
    .modulus     (modulus),
    .take        (take),
    .stat        (stat),
    .res         (res)
  );

  // Output register: hold while stalled, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      term_value <= res;
    end
  end

endmodule
